### sv/rvdec_pkg.sv
// rvdec_pkg: shared opcodes, kind and format codes and result types of the rv32i decoder
package rvdec_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned RegW  = 5;
  localparam int unsigned KindW = 6;
  localparam int unsigned FmtW  = 3;

  // major opcodes, bits [6:0] of the word
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
  localparam logic [6:0] OPC_OP     = 7'b0110011;

  // funct7 values that are told apart
  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  // funct3 values that need funct7 or pick the shift-immediate format
  localparam logic [2:0] F3_ADD_SUB = 3'b000;
  localparam logic [2:0] F3_SLL     = 3'b001;
  localparam logic [2:0] F3_SRL_SRA = 3'b101;

  typedef enum logic [KindW-1:0] {
    KIND_ILLEGAL = 6'd0,
    KIND_LUI     = 6'd1,
    KIND_AUIPC   = 6'd2,
    KIND_JAL     = 6'd3,
    KIND_JALR    = 6'd4,
    KIND_BEQ     = 6'd5,
    KIND_BNE     = 6'd6,
    KIND_BLT     = 6'd7,
    KIND_BGE     = 6'd8,
    KIND_BLTU    = 6'd9,
    KIND_BGEU    = 6'd10,
    KIND_LB      = 6'd11,
    KIND_LH      = 6'd12,
    KIND_LW      = 6'd13,
    KIND_LBU     = 6'd14,
    KIND_LHU     = 6'd15,
    KIND_SB      = 6'd16,
    KIND_SH      = 6'd17,
    KIND_SW      = 6'd18,
    KIND_ADDI    = 6'd19,
    KIND_SLTI    = 6'd20,
    KIND_SLTIU   = 6'd21,
    KIND_XORI    = 6'd22,
    KIND_ORI     = 6'd23,
    KIND_ANDI    = 6'd24,
    KIND_SLLI    = 6'd25,
    KIND_SRLI    = 6'd26,
    KIND_SRAI    = 6'd27,
    KIND_ADD     = 6'd28,
    KIND_SUB     = 6'd29,
    KIND_SLL     = 6'd30,
    KIND_SLT     = 6'd31,
    KIND_SLTU    = 6'd32,
    KIND_XOR     = 6'd33,
    KIND_SRL     = 6'd34,
    KIND_SRA     = 6'd35,
    KIND_OR      = 6'd36,
    KIND_AND     = 6'd37
  } kind_t;

  typedef enum logic [FmtW-1:0] {
    FMT_R    = 3'd0,
    FMT_I    = 3'd1,
    FMT_S    = 3'd2,
    FMT_B    = 3'd3,
    FMT_U    = 3'd4,
    FMT_J    = 3'd5,
    FMT_NONE = 3'd6
  } fmt_t;

  // classification handed from the classifier to the field extractor
  typedef struct packed {
    kind_t kind;
    fmt_t  fmt;
  } class_t;

  // register fields and immediate of one decoded word
  typedef struct packed {
    logic [WordW-1:0] imm;
    logic [RegW-1:0]  rs2;
    logic [RegW-1:0]  rs1;
    logic [RegW-1:0]  rd;
  } fields_t;

  // funct3 lookup tables; a hole means the encoding is reserved
  function automatic kind_t branch_kind(input logic [2:0] f3);
    kind_t k;
    case (f3)
      3'd0:    k = KIND_BEQ;
      3'd1:    k = KIND_BNE;
      3'd4:    k = KIND_BLT;
      3'd5:    k = KIND_BGE;
      3'd6:    k = KIND_BLTU;
      3'd7:    k = KIND_BGEU;
      default: k = KIND_ILLEGAL;
    endcase
    return k;
  endfunction

  function automatic kind_t load_kind(input logic [2:0] f3);
    kind_t k;
    case (f3)
      3'd0:    k = KIND_LB;
      3'd1:    k = KIND_LH;
      3'd2:    k = KIND_LW;
      3'd4:    k = KIND_LBU;
      3'd5:    k = KIND_LHU;
      default: k = KIND_ILLEGAL;
    endcase
    return k;
  endfunction

  function automatic kind_t store_kind(input logic [2:0] f3);
    kind_t k;
    case (f3)
      3'd0:    k = KIND_SB;
      3'd1:    k = KIND_SH;
      3'd2:    k = KIND_SW;
      default: k = KIND_ILLEGAL;
    endcase
    return k;
  endfunction

  function automatic kind_t opimm_kind(input logic [2:0] f3);
    kind_t k;
    case (f3)
      3'd0:    k = KIND_ADDI;
      3'd1:    k = KIND_SLLI;
      3'd2:    k = KIND_SLTI;
      3'd3:    k = KIND_SLTIU;
      3'd4:    k = KIND_XORI;
      3'd6:    k = KIND_ORI;
      3'd7:    k = KIND_ANDI;
      default: k = KIND_ILLEGAL;
    endcase
    return k;
  endfunction

  function automatic kind_t op_kind(input logic [2:0] f3);
    kind_t k;
    case (f3)
      3'd1:    k = KIND_SLL;
      3'd2:    k = KIND_SLT;
      3'd3:    k = KIND_SLTU;
      3'd4:    k = KIND_XOR;
      3'd6:    k = KIND_OR;
      3'd7:    k = KIND_AND;
      default: k = KIND_ILLEGAL;
    endcase
    return k;
  endfunction

endpackage

### sv/rvdec_classify.sv
// rvdec_classify: opcode, funct3 and funct7 decode into instruction kind and base format
module rvdec_classify (
  input  logic [rvdec_pkg::WordW-1:0] word,
  output rvdec_pkg::class_t           cls
);

  logic [6:0] opc;
  logic [2:0] f3;
  logic [6:0] f7;

  assign opc = word[6:0];
  assign f3  = word[14:12];
  assign f7  = word[31:25];

  always_comb begin
    rvdec_pkg::kind_t k;
    rvdec_pkg::fmt_t  f;
    k = rvdec_pkg::KIND_ILLEGAL;
    f = rvdec_pkg::FMT_NONE;
    case (opc)
      rvdec_pkg::OPC_LUI: begin
        k = rvdec_pkg::KIND_LUI;
        f = rvdec_pkg::FMT_U;
      end
      rvdec_pkg::OPC_AUIPC: begin
        k = rvdec_pkg::KIND_AUIPC;
        f = rvdec_pkg::FMT_U;
      end
      rvdec_pkg::OPC_JAL: begin
        k = rvdec_pkg::KIND_JAL;
        f = rvdec_pkg::FMT_J;
      end
      rvdec_pkg::OPC_JALR: begin
        // funct3 not checked
        k = rvdec_pkg::KIND_JALR;
        f = rvdec_pkg::FMT_I;
      end
      rvdec_pkg::OPC_BRANCH: begin
        k = rvdec_pkg::branch_kind(f3);
        f = rvdec_pkg::FMT_B;
      end
      rvdec_pkg::OPC_LOAD: begin
        k = rvdec_pkg::load_kind(f3);
        f = rvdec_pkg::FMT_I;
      end
      rvdec_pkg::OPC_STORE: begin
        k = rvdec_pkg::store_kind(f3);
        f = rvdec_pkg::FMT_S;
      end
      rvdec_pkg::OPC_OPIMM: begin
        if (f3 == rvdec_pkg::F3_SRL_SRA) begin
          if (f7 == rvdec_pkg::F7_BASE) k = rvdec_pkg::KIND_SRLI;
          else if (f7 == rvdec_pkg::F7_ALT) k = rvdec_pkg::KIND_SRAI;
          else k = rvdec_pkg::KIND_ILLEGAL;
        end else begin
          k = rvdec_pkg::opimm_kind(f3);
        end
        // shift-immediates carry shamt in the rs2 slot
        if (f3 == rvdec_pkg::F3_SLL || f3 == rvdec_pkg::F3_SRL_SRA) f = rvdec_pkg::FMT_R;
        else f = rvdec_pkg::FMT_I;
      end
      rvdec_pkg::OPC_OP: begin
        if (f3 == rvdec_pkg::F3_ADD_SUB) begin
          if (f7 == rvdec_pkg::F7_BASE) k = rvdec_pkg::KIND_ADD;
          else if (f7 == rvdec_pkg::F7_ALT) k = rvdec_pkg::KIND_SUB;
          else k = rvdec_pkg::KIND_ILLEGAL;
        end else if (f3 == rvdec_pkg::F3_SRL_SRA) begin
          if (f7 == rvdec_pkg::F7_BASE) k = rvdec_pkg::KIND_SRL;
          else if (f7 == rvdec_pkg::F7_ALT) k = rvdec_pkg::KIND_SRA;
          else k = rvdec_pkg::KIND_ILLEGAL;
        end else begin
          k = rvdec_pkg::op_kind(f3);
        end
        f = rvdec_pkg::FMT_R;
      end
      default: begin
        k = rvdec_pkg::KIND_ILLEGAL;
        f = rvdec_pkg::FMT_NONE;
      end
    endcase
    if (k == rvdec_pkg::KIND_ILLEGAL) f = rvdec_pkg::FMT_NONE;
    cls.kind = k;
    cls.fmt  = f;
  end

endmodule

### sv/rvdec_fields.sv
// rvdec_fields: register field selection and immediate assembly by base format
module rvdec_fields (
  input  logic [rvdec_pkg::WordW-1:0] word,
  input  rvdec_pkg::fmt_t             fmt,
  output rvdec_pkg::fields_t          fields
);

  logic sign;

  assign sign = word[31];

  always_comb begin
    fields.rd  = '0;
    fields.rs1 = '0;
    fields.rs2 = '0;
    fields.imm = '0;
    case (fmt)
      rvdec_pkg::FMT_R: begin
        fields.rd  = word[11:7];
        fields.rs1 = word[19:15];
        fields.rs2 = word[24:20];
      end
      rvdec_pkg::FMT_I: begin
        fields.rd  = word[11:7];
        fields.rs1 = word[19:15];
        fields.imm = {{21{sign}}, word[30:20]};
      end
      rvdec_pkg::FMT_S: begin
        fields.rs1 = word[19:15];
        fields.rs2 = word[24:20];
        fields.imm = {{21{sign}}, word[30:25], word[11:7]};
      end
      rvdec_pkg::FMT_B: begin
        fields.rs1 = word[19:15];
        fields.rs2 = word[24:20];
        fields.imm = {{20{sign}}, word[7], word[30:25], word[11:8], 1'b0};
      end
      rvdec_pkg::FMT_U: begin
        fields.rd  = word[11:7];
        fields.imm = {word[31:12], 12'b0};
      end
      rvdec_pkg::FMT_J: begin
        fields.rd  = word[11:7];
        fields.imm = {{12{sign}}, word[19:12], word[20], word[30:21], 1'b0};
      end
      default: begin
        fields.rd  = '0;
        fields.rs1 = '0;
        fields.rs2 = '0;
        fields.imm = '0;
      end
    endcase
  end

endmodule

### sv/rv32i_instruction_decoder_unit.sv
// rv32i_instruction_decoder_unit: top level of the rv32i decoder, input and result registers
//
// Decodes one 32-bit RV32I instruction word per item into its kind (LUI through AND, 0 for
// illegal), its base format (R, I, S, B, U, J, or none for illegal), the rd/rs1/rs2 fields that
// the format uses and the sign-extended immediate; fields a format does not use read as zero.
// Shift-immediates come out as R format with the shift amount in the rs2 slot. Each item sits
// in an input register, passes through the shallow decode logic and lands in the result
// register, which drives m_tvalid; one item is taken every cycle while the result side keeps
// up. The result register holds while it is full and m_tready is low, and the input register
// then holds behind it; s_tready follows the free space in the two stage registers, so it
// depends combinationally on m_tready.
module rv32i_instruction_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  // instruction side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] instr_word
  // result side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [4:0] dest_reg, [9:5] src1_reg, [14:10] src2_reg,
                                 // [46:15] immediate, [47] zero fill
  output logic [8:0]  m_tuser    // [5:0] kind, [8:6] format
);

  // input register stage
  logic                        s1_valid;
  logic [rvdec_pkg::WordW-1:0] s1_word;

  // result register stage
  logic                        out_valid;
  rvdec_pkg::class_t           out_cls;
  rvdec_pkg::fields_t          out_fields;

  // decode logic between the two stages
  rvdec_pkg::class_t           dec_cls;
  rvdec_pkg::fields_t          dec_fields;

  logic out_free;
  logic s1_free;

  // result register empties or drains this cycle
  assign out_free = !out_valid || m_tready;
  // input register empties or moves forward this cycle
  assign s1_free  = !s1_valid || out_free;
  assign s_tready = s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= s_tvalid;
    end
  end

  // word register: loads only on acceptance
  always_ff @(posedge clk) begin
    if (s_tvalid && s1_free) begin
      s1_word <= s_tdata;
    end
  end

  rvdec_classify u_classify (
    .word (s1_word),
    .cls  (dec_cls)
  );

  rvdec_fields u_fields (
    .word   (s1_word),
    .fmt    (dec_cls.fmt),
    .fields (dec_fields)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  // decoded result register, payload only
  always_ff @(posedge clk) begin
    if (s1_valid && out_free) begin
      out_cls    <= dec_cls;
      out_fields <= dec_fields;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_fields.imm, out_fields.rs2, out_fields.rs1, out_fields.rd};
  assign m_tuser  = {out_cls.fmt, out_cls.kind};

  // an accepted item always occupies the input stage next cycle
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> s1_valid)
    else $error("accepted item missing from input stage");

  // illegal kind and the none format always travel together
  a_illegal_pairs: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_cls.kind == rvdec_pkg::KIND_ILLEGAL) ==
                   (out_cls.fmt == rvdec_pkg::FMT_NONE)))
    else $error("kind and format disagree on illegal");

  // R format and illegal words carry no immediate
  a_r_no_imm: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_cls.fmt == rvdec_pkg::FMT_R || out_cls.fmt == rvdec_pkg::FMT_NONE))
      |-> (out_fields.imm == '0))
    else $error("immediate set for a format without one");

  // store and branch formats have no destination
  a_sb_no_rd: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_cls.fmt == rvdec_pkg::FMT_S || out_cls.fmt == rvdec_pkg::FMT_B))
      |-> (out_fields.rd == '0))
    else $error("destination set for a store or branch");

endmodule
